// ----- rtl/core/quaternion_vector_rotate_core_defines.svh -----
// assertion helpers shared by the rotate core
`ifndef QUATERNION_VECTOR_ROTATE_CORE_DEFINES_SVH
`define QUATERNION_VECTOR_ROTATE_CORE_DEFINES_SVH

// implication checked on every edge outside reset
`define QVR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition that must hold on every edge while reset is applied
`define QVR_ASSERT_IN_RESET(label, clk, rst_n, cons, msg) \
	label: assert property (@(posedge clk) (!rst_n) |-> (cons)) else $error(msg);

`endif

// ----- rtl/core/qvr_pkg.sv -----
`timescale 1ns / 1ps
package qvr_pkg;

	localparam int IN_W   = 16;
	localparam int T_W    = 34;   // first product, units of 2^-15
	localparam int M_W    = 50;   // second product terms, units of 2^-30
	localparam int P_W    = 51;   // pair sums
	localparam int S_W    = 52;   // full sum
	localparam int FRAC_W = 30;
	localparam int R_W    = S_W - FRAC_W;

	localparam logic signed [P_W-1:0] ROUND_BIAS = P_W'(64'sd1 <<< (FRAC_W - 1));
	localparam logic signed [R_W-1:0] OUT_MAX    = R_W'(32767);
	localparam logic signed [R_W-1:0] OUT_MIN    = -R_W'(32768);

	typedef struct packed {
		logic signed [IN_W-1:0] x;
		logic signed [IN_W-1:0] y;
		logic signed [IN_W-1:0] z;
	} vec_t;

	typedef struct packed {
		logic signed [IN_W-1:0] w;
		logic signed [IN_W-1:0] x;
		logic signed [IN_W-1:0] y;
		logic signed [IN_W-1:0] z;
	} quat_t;

	typedef struct packed {
		vec_t  vec;
		quat_t quat;
	} in_word_t;

	typedef struct packed {
		logic signed [T_W-1:0] t0;
		logic signed [T_W-1:0] t1;
		logic signed [T_W-1:0] t2;
		logic signed [T_W-1:0] t3;
		quat_t                 quat;
	} t_word_t;

	typedef struct packed {
		logic signed [P_W-1:0] ax;
		logic signed [P_W-1:0] bx;
		logic signed [P_W-1:0] ay;
		logic signed [P_W-1:0] by;
		logic signed [P_W-1:0] az;
		logic signed [P_W-1:0] bz;
	} pair_word_t;

	typedef struct packed {
		vec_t vec;
		logic saturated;
	} out_word_t;

endpackage

// ----- rtl/core/qvr_in_if.sv -----
`timescale 1ns / 1ps
interface qvr_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] vec_x;
	logic signed [15:0] vec_y;
	logic signed [15:0] vec_z;
	logic signed [15:0] quat_w;
	logic signed [15:0] quat_x;
	logic signed [15:0] quat_y;
	logic signed [15:0] quat_z;

	modport source (
		output valid, vec_x, vec_y, vec_z, quat_w, quat_x, quat_y, quat_z,
		input  ready
	);
	modport sink (
		input  valid, vec_x, vec_y, vec_z, quat_w, quat_x, quat_y, quat_z,
		output ready
	);
endinterface

// ----- rtl/core/qvr_out_if.sv -----
`timescale 1ns / 1ps
interface qvr_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] out_x;
	logic signed [15:0] out_y;
	logic signed [15:0] out_z;
	logic               saturated;

	modport source (
		output valid, out_x, out_y, out_z, saturated,
		input  ready
	);
	modport sink (
		input  valid, out_x, out_y, out_z, saturated,
		output ready
	);
endinterface

// ----- rtl/core/quaternion_vector_rotate_core.sv -----
// an accepted input word moves through the stage registers s1 to s6 in turn; s6 drives its result word at the output
// throughput: one word per cycle while the output is ready; each of the six stages holds one word and
// moves on when the stage after it is empty or moving, so bubbles close up
// reset: arst_n clears every stage valid bit at once; data registers are not reset
`timescale 1ns / 1ps
`include "quaternion_vector_rotate_core_defines.svh"
module quaternion_vector_rotate_core (
	input  logic             clk,
	input  logic             arst_n,
	qvr_in_if.sink           vec_in,
	qvr_out_if.source        vec_out
);
	import qvr_pkg::*;

	in_word_t   in_w;
	t_word_t    t_w;
	pair_word_t pair_w;
	out_word_t  out_w;
	logic       t_valid, t_ready;
	logic       pair_valid, pair_ready;

	assign in_w.vec.x  = vec_in.vec_x;
	assign in_w.vec.y  = vec_in.vec_y;
	assign in_w.vec.z  = vec_in.vec_z;
	assign in_w.quat.w = vec_in.quat_w;
	assign in_w.quat.x = vec_in.quat_x;
	assign in_w.quat.y = vec_in.quat_y;
	assign in_w.quat.z = vec_in.quat_z;

	qvr_tprod u_tprod (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vec_in.valid),
		.in_ready  (vec_in.ready),
		.in_data   (in_w),
		.out_valid (t_valid),
		.out_ready (t_ready),
		.out_data  (t_w)
	);

	qvr_rprod u_rprod (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (t_valid),
		.in_ready  (t_ready),
		.in_data   (t_w),
		.out_valid (pair_valid),
		.out_ready (pair_ready),
		.out_data  (pair_w)
	);

	qvr_rndsat u_rndsat (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pair_valid),
		.in_ready  (pair_ready),
		.in_data   (pair_w),
		.out_valid (vec_out.valid),
		.out_ready (vec_out.ready),
		.out_data  (out_w)
	);

	assign vec_out.out_x     = out_w.vec.x;
	assign vec_out.out_y     = out_w.vec.y;
	assign vec_out.out_z     = out_w.vec.z;
	assign vec_out.saturated = out_w.saturated;

	// a clipped word must show a rail value in some component
	`QVR_ASSERT_IMP(a_sat_has_rail, clk, arst_n, vec_out.valid && vec_out.saturated, (vec_out.out_x == 16'sh7fff) || (vec_out.out_x == 16'sh8000) || (vec_out.out_y == 16'sh7fff) || (vec_out.out_y == 16'sh8000) || (vec_out.out_z == 16'sh7fff) || (vec_out.out_z == 16'sh8000), "saturated set with no component at a rail")
	// the pipe only pushes back when a finished word is waiting
	`QVR_ASSERT_IMP(a_stall_needs_out, clk, arst_n, !vec_in.ready, vec_out.valid, "input stalled with empty output stage")
	`QVR_ASSERT_IN_RESET(a_reset_empty, clk, arst_n, !vec_out.valid, "output valid during reset")

endmodule

// ----- rtl/core/qvr_tprod.sv -----
`timescale 1ns / 1ps
module qvr_tprod (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  qvr_pkg::in_word_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output qvr_pkg::t_word_t   out_data
);
	import qvr_pkg::*;

	localparam int P_W1 = 2 * IN_W;

	logic                   valid_s1, valid_s2;
	logic                   en_s1, en_s2;
	logic signed [P_W1-1:0] p_xx_s1, p_yy_s1, p_zz_s1;
	logic signed [P_W1-1:0] p_wx_s1, p_yz_s1, p_zy_s1;
	logic signed [P_W1-1:0] p_wy_s1, p_xz_s1, p_zx_s1;
	logic signed [P_W1-1:0] p_wz_s1, p_xy_s1, p_yx_s1;
	quat_t                  quat_s1;
	t_word_t                data_s2;

	assign en_s2    = !valid_s2 || out_ready;
	assign en_s1    = !valid_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= in_valid;
			if (en_s2) valid_s2 <= valid_s1;
		end
	end

	// q * (0, v): twelve 16x16 products, then summed into t0 to t3
	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			p_xx_s1 <= in_data.quat.x * in_data.vec.x;
			p_yy_s1 <= in_data.quat.y * in_data.vec.y;
			p_zz_s1 <= in_data.quat.z * in_data.vec.z;
			p_wx_s1 <= in_data.quat.w * in_data.vec.x;
			p_yz_s1 <= in_data.quat.y * in_data.vec.z;
			p_zy_s1 <= in_data.quat.z * in_data.vec.y;
			p_wy_s1 <= in_data.quat.w * in_data.vec.y;
			p_xz_s1 <= in_data.quat.x * in_data.vec.z;
			p_zx_s1 <= in_data.quat.z * in_data.vec.x;
			p_wz_s1 <= in_data.quat.w * in_data.vec.z;
			p_xy_s1 <= in_data.quat.x * in_data.vec.y;
			p_yx_s1 <= in_data.quat.y * in_data.vec.x;
			quat_s1 <= in_data.quat;
		end
		if (en_s2 && valid_s1) begin
			data_s2.t0   <= -T_W'(p_xx_s1) - T_W'(p_yy_s1) - T_W'(p_zz_s1);
			data_s2.t1   <= T_W'(p_wx_s1) + T_W'(p_yz_s1) - T_W'(p_zy_s1);
			data_s2.t2   <= T_W'(p_wy_s1) - T_W'(p_xz_s1) + T_W'(p_zx_s1);
			data_s2.t3   <= T_W'(p_wz_s1) + T_W'(p_xy_s1) - T_W'(p_yx_s1);
			data_s2.quat <= quat_s1;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;

endmodule

// ----- rtl/core/qvr_rprod.sv -----
`timescale 1ns / 1ps
module qvr_rprod (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  qvr_pkg::t_word_t    in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output qvr_pkg::pair_word_t out_data
);
	import qvr_pkg::*;

	logic                  valid_s3, valid_s4;
	logic                  en_s3, en_s4;
	// t * conj(q), vector part only
	logic signed [M_W-1:0] m_0x_s3, m_1w_s3, m_2z_s3, m_3y_s3;
	logic signed [M_W-1:0] m_0y_s3, m_1z_s3, m_2w_s3, m_3x_s3;
	logic signed [M_W-1:0] m_0z_s3, m_1y_s3, m_2x_s3, m_3w_s3;
	pair_word_t            data_s4;

	assign en_s4    = !valid_s4 || out_ready;
	assign en_s3    = !valid_s3 || en_s4;
	assign in_ready = en_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en_s3) valid_s3 <= in_valid;
			if (en_s4) valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3 && in_valid) begin
			m_0x_s3 <= in_data.t0 * in_data.quat.x;
			m_1w_s3 <= in_data.t1 * in_data.quat.w;
			m_2z_s3 <= in_data.t2 * in_data.quat.z;
			m_3y_s3 <= in_data.t3 * in_data.quat.y;
			m_0y_s3 <= in_data.t0 * in_data.quat.y;
			m_1z_s3 <= in_data.t1 * in_data.quat.z;
			m_2w_s3 <= in_data.t2 * in_data.quat.w;
			m_3x_s3 <= in_data.t3 * in_data.quat.x;
			m_0z_s3 <= in_data.t0 * in_data.quat.z;
			m_1y_s3 <= in_data.t1 * in_data.quat.y;
			m_2x_s3 <= in_data.t2 * in_data.quat.x;
			m_3w_s3 <= in_data.t3 * in_data.quat.w;
		end
		// rounding offset rides in the first pair of each component
		if (en_s4 && valid_s3) begin
			data_s4.ax <= P_W'(m_1w_s3) - P_W'(m_0x_s3) + ROUND_BIAS;
			data_s4.bx <= P_W'(m_3y_s3) - P_W'(m_2z_s3);
			data_s4.ay <= P_W'(m_1z_s3) - P_W'(m_0y_s3) + ROUND_BIAS;
			data_s4.by <= P_W'(m_2w_s3) - P_W'(m_3x_s3);
			data_s4.az <= P_W'(m_2x_s3) - P_W'(m_0z_s3) + ROUND_BIAS;
			data_s4.bz <= P_W'(m_3w_s3) - P_W'(m_1y_s3);
		end
	end

	assign out_valid = valid_s4;
	assign out_data  = data_s4;

endmodule

// ----- rtl/core/qvr_rndsat.sv -----
`timescale 1ns / 1ps
module qvr_rndsat (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  qvr_pkg::pair_word_t in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output qvr_pkg::out_word_t  out_data
);
	import qvr_pkg::*;

	logic                  valid_s5, valid_s6;
	logic                  en_s5, en_s6;
	logic signed [S_W-1:0] sum_x_s5, sum_y_s5, sum_z_s5;
	logic signed [R_W-1:0] rnd_x, rnd_y, rnd_z;
	logic                  hi_x, hi_y, hi_z, lo_x, lo_y, lo_z;
	out_word_t             clip_w;
	out_word_t             data_s6;

	assign en_s6    = !valid_s6 || out_ready;
	assign en_s5    = !valid_s5 || en_s6;
	assign in_ready = en_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			if (en_s5) valid_s5 <= in_valid;
			if (en_s6) valid_s6 <= valid_s5;
		end
	end

	// floor of the biased sum gives round half up
	assign rnd_x = sum_x_s5[S_W-1:FRAC_W];
	assign rnd_y = sum_y_s5[S_W-1:FRAC_W];
	assign rnd_z = sum_z_s5[S_W-1:FRAC_W];

	assign hi_x = rnd_x > OUT_MAX;
	assign hi_y = rnd_y > OUT_MAX;
	assign hi_z = rnd_z > OUT_MAX;
	assign lo_x = rnd_x < OUT_MIN;
	assign lo_y = rnd_y < OUT_MIN;
	assign lo_z = rnd_z < OUT_MIN;

	always_comb begin
		clip_w.vec.x = hi_x ? OUT_MAX[IN_W-1:0] : (lo_x ? OUT_MIN[IN_W-1:0] : rnd_x[IN_W-1:0]);
		clip_w.vec.y = hi_y ? OUT_MAX[IN_W-1:0] : (lo_y ? OUT_MIN[IN_W-1:0] : rnd_y[IN_W-1:0]);
		clip_w.vec.z = hi_z ? OUT_MAX[IN_W-1:0] : (lo_z ? OUT_MIN[IN_W-1:0] : rnd_z[IN_W-1:0]);
		clip_w.saturated = hi_x || hi_y || hi_z || lo_x || lo_y || lo_z;
	end

	always_ff @(posedge clk) begin
		if (en_s5 && in_valid) begin
			sum_x_s5 <= S_W'(in_data.ax) + S_W'(in_data.bx);
			sum_y_s5 <= S_W'(in_data.ay) + S_W'(in_data.by);
			sum_z_s5 <= S_W'(in_data.az) + S_W'(in_data.bz);
		end
		if (en_s6 && valid_s5) begin
			data_s6 <= clip_w;
		end
	end

	assign out_valid = valid_s6;
	assign out_data  = data_s6;

endmodule

// ----- tb/tb_quaternion_vector_rotate_core.sv -----
`timescale 1ns / 1ps
module tb_quaternion_vector_rotate_core;
	import qvr_pkg::*;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int RANDOM_WORDS  = 200;
	localparam int LONG_HOLD     = 80;
	localparam int DRAIN_CYCLES  = 20;
	localparam int REPORT_LIMIT  = 10;

	class rotation_tracker;
		out_word_t expected_rotations[$];
		int        mismatches;

		function void hamilton(input longint a[4], input longint b[4], output longint r[4]);
			r[0] = a[0] * b[0] - a[1] * b[1] - a[2] * b[2] - a[3] * b[3];
			r[1] = a[0] * b[1] + a[1] * b[0] + a[2] * b[3] - a[3] * b[2];
			r[2] = a[0] * b[2] - a[1] * b[3] + a[2] * b[0] + a[3] * b[1];
			r[3] = a[0] * b[3] + a[1] * b[2] - a[2] * b[1] + a[3] * b[0];
		endfunction

		// q * (0, v) * conj(q), rounded half up, clipped to 16 bits
		function out_word_t rotated(in_word_t w);
			longint             q[4];
			longint             qc[4];
			longint             pv[4];
			longint             t[4];
			longint             r[4];
			longint             c;
			logic signed [15:0] comp[3];
			out_word_t          o;
			q[0] = w.quat.w;
			q[1] = w.quat.x;
			q[2] = w.quat.y;
			q[3] = w.quat.z;
			pv[0] = 0;
			pv[1] = w.vec.x;
			pv[2] = w.vec.y;
			pv[3] = w.vec.z;
			qc[0] = q[0];
			qc[1] = -q[1];
			qc[2] = -q[2];
			qc[3] = -q[3];
			hamilton(q, pv, t);
			hamilton(t, qc, r);
			o.saturated = 1'b0;
			for (int k = 0; k < 3; k++) begin
				c = (r[k + 1] + (64'sd1 <<< 29)) >>> 30;
				if (c > 32767) begin
					c = 32767;
					o.saturated = 1'b1;
				end else if (c < -32768) begin
					c = -32768;
					o.saturated = 1'b1;
				end
				comp[k] = 16'(c);
			end
			o.vec.x = comp[0];
			o.vec.y = comp[1];
			o.vec.z = comp[2];
			return o;
		endfunction

		function void note_input(in_word_t w);
			expected_rotations.push_back(rotated(w));
		endfunction

		function void check_result(out_word_t got);
			out_word_t exp_word;
			if (expected_rotations.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("%0t: unexpected word x=%0d y=%0d z=%0d sat=%0b", $time,
						got.vec.x, got.vec.y, got.vec.z, got.saturated);
				return;
			end
			exp_word = expected_rotations.pop_front();
			if (got.vec.x !== exp_word.vec.x || got.vec.y !== exp_word.vec.y ||
					got.vec.z !== exp_word.vec.z || got.saturated !== exp_word.saturated) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("%0t: mismatch exp x=%0d y=%0d z=%0d sat=%0b got x=%0d y=%0d z=%0d sat=%0b",
						$time, exp_word.vec.x, exp_word.vec.y, exp_word.vec.z,
						exp_word.saturated, got.vec.x, got.vec.y, got.vec.z, got.saturated);
			end
		endfunction

		function int pending();
			return expected_rotations.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   cycle_count = 0;
	int   tx_idle_pct;
	int   rx_stall_pct;
	logic hold_req;
	logic hold_ack;
	int   hold_left;

	rotation_tracker tracker = new();

	qvr_in_if  vec_in();
	qvr_out_if vec_out();

	quaternion_vector_rotate_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.vec_in  (vec_in),
		.vec_out (vec_out)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("** quaternion_vector_rotate_core: FAILED **");
			$finish;
		end
	end

	// scoreboard taps on both channels
	always @(posedge clk) begin
		out_word_t got;
		if (arst_n) begin
			if (vec_in.valid && vec_in.ready)
				tracker.note_input({vec_in.vec_x, vec_in.vec_y, vec_in.vec_z,
					vec_in.quat_w, vec_in.quat_x, vec_in.quat_y, vec_in.quat_z});
			if (vec_out.valid && vec_out.ready) begin
				got.vec.x = vec_out.out_x;
				got.vec.y = vec_out.out_y;
				got.vec.z = vec_out.out_z;
				got.saturated = vec_out.saturated;
				tracker.check_result(got);
			end
		end
	end

	// output side: random stalls, plus one long hold on request
	initial begin
		vec_out.ready = 1'b0;
		hold_ack = 1'b0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				vec_out.ready <= 1'b0;
			end else if (hold_req != hold_ack) begin
				hold_ack = hold_req;
				hold_left = LONG_HOLD - 1;
				vec_out.ready <= 1'b0;
			end else begin
				vec_out.ready <= ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	function automatic logic signed [15:0] span(int lo, int hi);
		return 16'(lo + int'($urandom_range(hi - lo)));
	endfunction

	function automatic logic signed [15:0] edge_value();
		case ($urandom_range(4))
			0: return -16'sd32768;
			1: return 16'sd32767;
			2: return 16'sd0;
			3: return -16'sd1;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic in_word_t word_of(int vx, int vy, int vz, int qw, int qx, int qy, int qz);
		in_word_t w;
		w.vec.x = 16'(vx);
		w.vec.y = 16'(vy);
		w.vec.z = 16'(vz);
		w.quat.w = 16'(qw);
		w.quat.x = 16'(qx);
		w.quat.y = 16'(qy);
		w.quat.z = 16'(qz);
		return w;
	endfunction

	function automatic in_word_t random_word();
		in_word_t w;
		int       kind;
		kind = $urandom_range(9);
		w = in_word_t'({$urandom, $urandom, $urandom, 16'($urandom)});
		if (kind >= 4 && kind <= 6) begin
			// length at most one, so mostly no clipping
			w.quat.w = span(-16384, 16383);
			w.quat.x = span(-16384, 16383);
			w.quat.y = span(-16384, 16383);
			w.quat.z = span(-16384, 16383);
		end else if (kind >= 7 && kind <= 8) begin
			w.quat.w = span(-8192, 8191);
			w.quat.x = span(-8192, 8191);
			w.quat.y = span(-8192, 8191);
			w.quat.z = span(-8192, 8191);
		end else if (kind == 9) begin
			w.vec.x = edge_value();
			w.vec.y = edge_value();
			w.vec.z = edge_value();
			w.quat.w = edge_value();
			w.quat.x = edge_value();
			w.quat.y = edge_value();
			w.quat.z = edge_value();
		end
		return w;
	endfunction

	task automatic send_word(in_word_t w);
		while ($urandom_range(99) < tx_idle_pct) begin
			vec_in.valid <= 1'b0;
			@(posedge clk);
		end
		vec_in.valid <= 1'b1;
		vec_in.vec_x <= w.vec.x;
		vec_in.vec_y <= w.vec.y;
		vec_in.vec_z <= w.vec.z;
		vec_in.quat_w <= w.quat.w;
		vec_in.quat_x <= w.quat.x;
		vec_in.quat_y <= w.quat.y;
		vec_in.quat_z <= w.quat.z;
		@(posedge clk);
		while (!vec_in.ready)
			@(posedge clk);
	endtask

	task automatic wait_drain();
		vec_in.valid <= 1'b0;
		@(posedge clk);
		while (tracker.pending() != 0)
			@(posedge clk);
	endtask

	initial begin
		in_word_t directed[$];
		arst_n = 1'b0;
		hold_req = 1'b0;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		vec_in.valid = 1'b0;
		vec_in.vec_x = '0;
		vec_in.vec_y = '0;
		vec_in.vec_z = '0;
		vec_in.quat_w = '0;
		vec_in.quat_x = '0;
		vec_in.quat_y = '0;
		vec_in.quat_z = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed.push_back(word_of(0, 0, 0, 0, 0, 0, 0));
		directed.push_back(word_of(32767, -32768, 1, 32767, 0, 0, 0));
		// scalar of minus one is exact, vector comes back unchanged
		directed.push_back(word_of(32767, -32768, -1, -32768, 0, 0, 0));
		directed.push_back(word_of(100, 200, 300, 0, -32768, 0, 0));
		directed.push_back(word_of(1000, -1000, 0, 23170, 0, 0, 23170));
		directed.push_back(word_of(-32768, 32767, -32768, 23170, 23170, 0, 0));
		// exact half ties: plus half rounds up, minus half rounds to zero
		directed.push_back(word_of(2, 0, 0, 0, 16384, 0, 0));
		directed.push_back(word_of(-2, 0, 0, 0, 16384, 0, 0));
		directed.push_back(word_of(0, 2, -2, 0, 16384, 0, 0));
		directed.push_back(word_of(32767, 32767, 32767, 32767, 32767, 32767, 32767));
		directed.push_back(word_of(-32768, -32768, -32768, -32768, -32768, -32768, -32768));
		directed.push_back(word_of(32767, -32768, 0, -32768, -32768, -32768, -32768));
		directed.push_back(word_of(0, 32767, 0, 32767, 32767, 0, 0));
		directed.push_back(word_of(-1, -1, -1, -32768, 32767, -32768, 32767));
		directed.push_back(word_of(12345, -23456, 7, 16384, -16384, 16384, -16384));
		foreach (directed[i])
			send_word(directed[i]);
		wait_drain();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					tx_idle_pct = 0;
					rx_stall_pct <= 0;
				end
				1: begin
					tx_idle_pct = 55;
					rx_stall_pct <= 0;
				end
				2: begin
					tx_idle_pct = 0;
					rx_stall_pct <= 55;
				end
				default: begin
					tx_idle_pct = 25;
					rx_stall_pct <= 25;
				end
			endcase
			for (int i = 0; i < RANDOM_WORDS; i++) begin
				// back up the pipe once while the input keeps offering words
				if (ph == 0 && i == RANDOM_WORDS / 2)
					hold_req <= ~hold_req;
				send_word(random_word());
			end
			wait_drain();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.pending() == 0)
			$display("** quaternion_vector_rotate_core: PASSED **");
		else
			$display("** quaternion_vector_rotate_core: FAILED **");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/qvr_pkg.sv
rtl/core/qvr_in_if.sv
rtl/core/qvr_out_if.sv
rtl/core/qvr_tprod.sv
rtl/core/qvr_rprod.sv
rtl/core/qvr_rndsat.sv
rtl/core/quaternion_vector_rotate_core.sv
tb/tb_quaternion_vector_rotate_core.sv
